// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OLIST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OLIST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/olist_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered list engine package
// Request and status codes plus the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package olist_pkg;

  localparam logic [2:0] FN_PUSH_FRONT   = 3'd0;
  localparam logic [2:0] FN_PUSH_BACK    = 3'd1;
  localparam logic [2:0] FN_INSERT_AT    = 3'd2;
  localparam logic [2:0] FN_REMOVE_FIRST = 3'd3;
  localparam logic [2:0] FN_REMOVE_ALL   = 3'd4;
  localparam logic [2:0] FN_SEARCH       = 3'd5;
  localparam logic [2:0] FN_COUNT_GT     = 3'd6;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic load_req;
    logic set_full;
    logic set_empty;
    logic ins_init;
    logic ins_read;
    logic ins_shift;
    logic ins_place;
    logic scan_init;
    logic scan_read;
    logic scan_eval;
    logic scan_close;
    logic tail_read;
    logic tail_capture;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_insert;
    logic is_scan;
    logic full;
    logic empty;
    logic at_tgt;
    logic scan_end;
    logic search_hit;
  } dp_stat_t;

endpackage

// ===== hdl/olist_datapath.sv =====
// ----------------------------------------------------------------------------
// Ordered list datapath
// Entry memory, scan and shift pointers, running sum and the result registers.
// ----------------------------------------------------------------------------
module olist_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  olist_pkg::dp_cmd_t   cmd,
  output olist_pkg::dp_stat_t  stat,
  input  logic [2:0]           in_func,
  input  logic signed [31:0]   in_operand_value,
  input  logic [6:0]           in_insert_position,
  output logic [1:0]           out_status,
  output logic [6:0]           out_entry_count,
  output logic signed [37:0]   out_entry_sum,
  output logic signed [31:0]   out_tail_value,
  output logic [6:0]           out_match_position,
  output logic [6:0]           out_greater_count,
  output logic [6:0]           out_removed_count
);
  import olist_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);

  logic [31:0]        mem [CAPACITY];
  logic [31:0]        rdata_r;

  logic [2:0]         func_r;
  logic [31:0]        val_r;
  logic [6:0]         pos_r;
  logic [LW-1:0]      len_r;
  logic [37:0]        sum_r;
  logic [LW-1:0]      ptr_r;
  logic [LW-1:0]      wp_r;
  logic [LW-1:0]      tgt_r;
  logic [1:0]         status_r;
  logic [LW-1:0]      match_r;
  logic [LW-1:0]      greater_r;
  logic [LW-1:0]      removed_r;
  logic [31:0]        tail_r;

  logic [1:0]         o_status_r;
  logic [6:0]         o_count_r;
  logic [37:0]        o_sum_r;
  logic [31:0]        o_tail_r;
  logic [6:0]         o_match_r;
  logic [6:0]         o_greater_r;
  logic [6:0]         o_removed_r;

  logic               is_remove;
  logic               hit;
  logic               drop;
  logic               keep_wr;
  logic [LW-1:0]      ptr_m1;
  logic [LW-1:0]      len_m1;
  logic [6:0]         pos_idx;
  logic [LW-1:0]      tgt_nxt;
  logic [37:0]        val_ext;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [31:0]        wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;

  assign is_remove = (func_r == FN_REMOVE_FIRST) || (func_r == FN_REMOVE_ALL);
  assign hit       = (rdata_r == val_r);
  // Remove first drops only the earliest match; remove all drops every one.
  assign drop      = is_remove && hit && ((func_r == FN_REMOVE_ALL) || (removed_r == '0));
  assign keep_wr   = cmd.scan_eval && is_remove && !drop;
  assign ptr_m1    = ptr_r - 1'b1;
  assign len_m1    = len_r - 1'b1;
  assign pos_idx   = (pos_r == 7'd0) ? 7'd0 : pos_r - 7'd1;
  assign val_ext   = {{6{val_r[31]}}, val_r};

  always_comb begin
    unique case (func_r)
      FN_PUSH_FRONT: tgt_nxt = '0;
      FN_PUSH_BACK:  tgt_nxt = len_r;
      default:       tgt_nxt = (pos_idx >= len_r) ? len_r : LW'(pos_idx);
    endcase
  end

  assign stat.is_insert  = (func_r <= FN_INSERT_AT);
  assign stat.is_scan    = (func_r >= FN_REMOVE_FIRST) && (func_r <= FN_COUNT_GT);
  assign stat.full       = (len_r == LW'(CAPACITY));
  assign stat.empty      = (len_r == '0);
  assign stat.at_tgt     = (ptr_r == tgt_r);
  assign stat.scan_end   = (ptr_r == len_r);
  assign stat.search_hit = (func_r == FN_SEARCH) && hit;

  // Memory port selection.
  always_comb begin
    wr_en   = cmd.ins_shift || cmd.ins_place || keep_wr;
    wr_data = cmd.ins_place ? val_r : rdata_r;
    priority if (cmd.ins_shift) begin
      wr_addr = ptr_r[AW-1:0];
    end else if (cmd.ins_place) begin
      wr_addr = tgt_r[AW-1:0];
    end else begin
      wr_addr = wp_r[AW-1:0];
    end
    rd_en = cmd.ins_read || cmd.scan_read || (cmd.tail_read && !stat.empty);
    priority if (cmd.ins_read) begin
      rd_addr = ptr_m1[AW-1:0];
    end else if (cmd.scan_read) begin
      rd_addr = ptr_r[AW-1:0];
    end else begin
      rd_addr = len_m1[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // List length and running sum are the persistent state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      sum_r <= '0;
    end else begin
      if (cmd.ins_place) begin
        len_r <= len_r + 1'b1;
        sum_r <= sum_r + val_ext;
      end
      if (cmd.scan_eval && drop) begin
        sum_r <= sum_r - val_ext;
      end
      if (cmd.scan_close && is_remove) begin
        len_r <= wp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      func_r    <= in_func;
      val_r     <= in_operand_value;
      pos_r     <= in_insert_position;
      status_r  <= ST_OK;
      match_r   <= '0;
      greater_r <= '0;
      removed_r <= '0;
    end
    if (cmd.set_full) begin
      status_r <= ST_FULL;
    end
    if (cmd.set_empty) begin
      status_r <= ST_EMPTY;
    end
    if (cmd.ins_init) begin
      ptr_r <= len_r;
      tgt_r <= tgt_nxt;
    end
    if (cmd.ins_shift) begin
      ptr_r <= ptr_m1;
    end
    if (cmd.scan_init) begin
      ptr_r <= '0;
      wp_r  <= '0;
    end
    if (cmd.scan_eval) begin
      ptr_r <= ptr_r + 1'b1;
      if (drop) begin
        removed_r <= removed_r + 1'b1;
      end
      if (keep_wr) begin
        wp_r <= wp_r + 1'b1;
      end
      if (stat.search_hit) begin
        match_r <= ptr_r + 1'b1;
      end
      if ((func_r == FN_COUNT_GT) && ($signed(rdata_r) > $signed(val_r))) begin
        greater_r <= greater_r + 1'b1;
      end
    end
    if (cmd.scan_close) begin
      if ((is_remove && (removed_r == '0)) || ((func_r == FN_SEARCH) && (match_r == '0)))
      begin
        status_r <= ST_NOT_FOUND;
      end
    end
    if (cmd.tail_read && stat.empty) begin
      tail_r <= '0;
    end
    if (cmd.tail_capture) begin
      tail_r <= rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_status_r  <= status_r;
      o_count_r   <= 7'(len_r);
      o_sum_r     <= sum_r;
      o_tail_r    <= tail_r;
      o_match_r   <= 7'(match_r);
      o_greater_r <= 7'(greater_r);
      o_removed_r <= 7'(removed_r);
    end
  end

  assign out_status         = o_status_r;
  assign out_entry_count    = o_count_r;
  assign out_entry_sum      = $signed(o_sum_r);
  assign out_tail_value     = $signed(o_tail_r);
  assign out_match_position = o_match_r;
  assign out_greater_count  = o_greater_r;
  assign out_removed_count  = o_removed_r;

endmodule

// ===== hdl/olist_ctrl.sv =====
// ----------------------------------------------------------------------------
// Ordered list controller
// Sequences the shift, scan, tail read and result hand-off for each item.
// ----------------------------------------------------------------------------
module olist_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  olist_pkg::dp_stat_t  stat,
  output olist_pkg::dp_cmd_t   cmd
);
  import olist_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE      = 10'b00_0000_0001,
    S_CHECK     = 10'b00_0000_0010,
    S_SHIFT_RD  = 10'b00_0000_0100,
    S_SHIFT_WR  = 10'b00_0000_1000,
    S_SCAN_RD   = 10'b00_0001_0000,
    S_SCAN_EV   = 10'b00_0010_0000,
    S_CLOSE     = 10'b00_0100_0000,
    S_TAIL      = 10'b00_1000_0000,
    S_TAIL_WAIT = 10'b01_0000_0000,
    S_RESP      = 10'b10_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (stat.is_insert && stat.full) begin
          cmd.set_full = 1'b1;
          state_nxt    = S_TAIL;
        end else if (stat.is_insert) begin
          cmd.ins_init = 1'b1;
          state_nxt    = S_SHIFT_RD;
        end else if (stat.is_scan && stat.empty) begin
          cmd.set_empty = 1'b1;
          state_nxt     = S_TAIL;
        end else if (stat.is_scan) begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN_RD;
        end else begin
          state_nxt = S_TAIL;
        end
      end
      S_SHIFT_RD: begin
        // Entries above the target move up one place, last entry first.
        if (stat.at_tgt) begin
          cmd.ins_place = 1'b1;
          state_nxt     = S_TAIL;
        end else begin
          cmd.ins_read = 1'b1;
          state_nxt    = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.ins_shift = 1'b1;
        state_nxt     = S_SHIFT_RD;
      end
      S_SCAN_RD: begin
        if (stat.scan_end) begin
          state_nxt = S_CLOSE;
        end else begin
          cmd.scan_read = 1'b1;
          state_nxt     = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        cmd.scan_eval = 1'b1;
        state_nxt     = stat.search_hit ? S_CLOSE : S_SCAN_RD;
      end
      S_CLOSE: begin
        cmd.scan_close = 1'b1;
        state_nxt      = S_TAIL;
      end
      S_TAIL: begin
        cmd.tail_read = 1'b1;
        state_nxt     = stat.empty ? S_RESP : S_TAIL_WAIT;
      end
      S_TAIL_WAIT: begin
        cmd.tail_capture = 1'b1;
        state_nxt        = S_RESP;
      end
      S_RESP: begin
        // The result register takes the item once its previous content is gone.
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/ordered_list_engine.sv =====
// Each item runs alone: an insert moves the entries above its place up one by one,
// a scan reads the entries in turn (a search stops at its first hit), then the
// tail entry is read, which is skipped when the list ends empty, and the result
// loads. One item is in work at a time; the next is taken once the result has
// loaded and the controller is back in idle, and out_stall can hold the load.
// Reset clears the length, sum and control state; entries need no clearing pass.
// ----------------------------------------------------------------------------
// Ordered list engine
// Bounded ordered list of signed 32-bit values with insert, remove, search
// and count requests, each answered with status, length, sum, tail, match position and greater and removed counts.
// ----------------------------------------------------------------------------
module ordered_list_engine #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_func,
  input  logic signed [31:0]  in_operand_value,
  input  logic [6:0]          in_insert_position,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic [6:0]          out_entry_count,
  output logic signed [37:0]  out_entry_sum,
  output logic signed [31:0]  out_tail_value,
  output logic [6:0]          out_match_position,
  output logic [6:0]          out_greater_count,
  output logic [6:0]          out_removed_count
);
  import olist_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  olist_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  olist_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_func            (in_func),
    .in_operand_value   (in_operand_value),
    .in_insert_position (in_insert_position),
    .out_status         (out_status),
    .out_entry_count    (out_entry_count),
    .out_entry_sum      (out_entry_sum),
    .out_tail_value     (out_tail_value),
    .out_match_position (out_match_position),
    .out_greater_count  (out_greater_count),
    .out_removed_count  (out_removed_count)
  );

endmodule

// ===== hdl/olist_checker.sv =====
// ----------------------------------------------------------------------------
// Ordered list checker
// Port-level assertions on the ordered list engine, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module olist_checker #(
  parameter int CAPACITY = 64
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [1:0]          out_status,
  input logic [6:0]          out_entry_count,
  input logic signed [37:0]  out_entry_sum,
  input logic signed [31:0]  out_tail_value,
  input logic [6:0]          out_match_position,
  input logic [6:0]          out_greater_count,
  input logic [6:0]          out_removed_count
);
  import olist_pkg::*;

  logic         in_take;
  logic         stalled_out;
  logic [99:0]  out_word;
  logic         fail_out;
  logic         quiet_out;
  logic         empty_out;
  logic         blank_out;

  assign in_take     = in_valid && !in_stall;
  assign stalled_out = out_valid && out_stall;
  assign out_word    = {out_status, out_entry_count, out_entry_sum, out_tail_value,
                        out_match_position, out_greater_count, out_removed_count};
  assign fail_out    = out_valid && (out_status != ST_OK);
  assign quiet_out   = (out_removed_count == 7'd0) && (out_match_position == 7'd0);
  assign empty_out   = (CAPACITY < 128) && out_valid && (out_entry_count == 7'd0);
  assign blank_out   = (out_tail_value == 32'sd0) && (out_entry_sum == 38'sd0);

  `OLIST_ASSERT_NEXT(a_out_hold, stalled_out, out_valid, "stalled result dropped")
  `OLIST_ASSERT_NEXT(a_out_stable, stalled_out, $stable(out_word), "stalled result changed")
  `OLIST_ASSERT_NEXT(a_in_busy, in_take, in_stall, "second item taken while one is in work")
  `OLIST_ASSERT_NOW(a_fail_quiet, fail_out, quiet_out, "failed request reports a match")
  `OLIST_ASSERT_NOW(a_empty_zero, empty_out, blank_out, "empty list with nonzero tail or sum")

endmodule

bind ordered_list_engine olist_checker #(.CAPACITY(CAPACITY)) u_olist_checker (.*);

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Ordered list engine testbench
// Sends list requests through the valid/stall handshake and predicts every
// reply from a queue that mirrors the list. Each reply is checked field by
// field in order, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import olist_pkg::*;

  typedef logic signed [31:0] value_t;

  typedef struct {
    logic [1:0]         status;
    logic [6:0]         entry_count;
    logic signed [37:0] entry_sum;
    logic signed [31:0] tail_value;
    logic [6:0]         match_position;
    logic [6:0]         greater_count;
    logic [6:0]         removed_count;
  } list_reply_t;

  localparam int         LIST_CAPACITY = 64;
  localparam int         HOLD_CYCLES   = 400;
  localparam logic [2:0] FN_UNUSED     = 3'd7;
  localparam value_t     VAL_MIN       = 32'sh8000_0000;
  localparam value_t     VAL_MAX       = 32'sh7FFF_FFFF;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         in_func = FN_PUSH_FRONT;
  value_t             in_operand_value = '0;
  logic [6:0]         in_insert_position = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_status;
  logic [6:0]         out_entry_count;
  logic signed [37:0] out_entry_sum;
  logic signed [31:0] out_tail_value;
  logic [6:0]         out_match_position;
  logic [6:0]         out_greater_count;
  logic [6:0]         out_removed_count;

  value_t      list_model[$];
  list_reply_t expected_replies[$];
  list_reply_t oldest_reply;
  int          mismatch_count = 0;
  int          burst_left = 0;
  logic        hold_off_req = 1'b0;

  ordered_list_engine #(
    .CAPACITY(LIST_CAPACITY)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_operand_value   (in_operand_value),
    .in_insert_position (in_insert_position),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_entry_count    (out_entry_count),
    .out_entry_sum      (out_entry_sum),
    .out_tail_value     (out_tail_value),
    .out_match_position (out_match_position),
    .out_greater_count  (out_greater_count),
    .out_removed_count  (out_removed_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(8_000_000);
    $display("testbench: FAIL");
    $finish;
  end

  // Applies one request to the mirrored list and returns the reply it causes.
  function automatic list_reply_t apply_request(input logic [2:0] f, input value_t v,
                                                input logic [6:0] p);
    list_reply_t r;
    value_t      kept[$];
    int          idx;
    longint      total;
    r = '{default: 0};
    case (f)
      FN_PUSH_FRONT, FN_PUSH_BACK, FN_INSERT_AT: begin
        if (list_model.size() >= LIST_CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          if (f == FN_PUSH_FRONT) idx = 0;
          else if (f == FN_PUSH_BACK) idx = list_model.size();
          else idx = (p == 0) ? 0 : int'(p) - 1;
          if (idx > list_model.size()) idx = list_model.size();
          list_model.insert(idx, v);
        end
      end
      FN_REMOVE_FIRST, FN_REMOVE_ALL, FN_SEARCH, FN_COUNT_GT: begin
        if (list_model.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          idx = 0;
          while (idx < list_model.size() && list_model[idx] != v) idx++;
          case (f)
            FN_REMOVE_FIRST: begin
              if (idx == list_model.size()) begin
                r.status = ST_NOT_FOUND;
              end else begin
                list_model.delete(idx);
                r.removed_count = 7'd1;
              end
            end
            FN_REMOVE_ALL: begin
              foreach (list_model[k]) begin
                if (list_model[k] == v) r.removed_count++;
                else kept.push_back(list_model[k]);
              end
              list_model = kept;
              if (r.removed_count == 0) r.status = ST_NOT_FOUND;
            end
            FN_SEARCH: begin
              if (idx == list_model.size()) r.status = ST_NOT_FOUND;
              else r.match_position = 7'(idx + 1);
            end
            default: begin
              foreach (list_model[k]) begin
                if (list_model[k] > v) r.greater_count++;
              end
            end
          endcase
        end
      end
      default: ;
    endcase
    total = 0;
    foreach (list_model[k]) total += list_model[k];
    r.entry_count = 7'(list_model.size());
    r.entry_sum = total[37:0];
    if (list_model.size() > 0) r.tail_value = list_model[list_model.size() - 1];
    return r;
  endfunction

  function automatic value_t pick_value();
    value_t pool[8];
    int     roll;
    pool = '{VAL_MIN, VAL_MAX, 0, -1, 1, 5, 1000, -77};
    roll = $urandom_range(99);
    if (roll < 25 && list_model.size() > 0) return list_model[$urandom_range(list_model.size() - 1)];
    if (roll < 65) return pool[$urandom_range(7)];
    return value_t'($urandom);
  endfunction

  function automatic logic [6:0] pick_position();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return 7'd0;
    if (roll < 20) return 7'($urandom_range(127));
    return 7'($urandom_range(list_model.size() + 1));
  endfunction

  // Ends the current burst now and then, leaving the input idle for a while.
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end
  endtask

  // Called at a rising edge; returns once the item was taken, after any idle gap that pace_sender adds.
  task automatic send_request(input logic [2:0] f, input value_t v, input logic [6:0] p);
    in_valid           <= 1'b1;
    in_func            <= f;
    in_operand_value   <= v;
    in_insert_position <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_replies.push_back(apply_request(f, v, p));
    pace_sender();
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_list();
    send_request(FN_REMOVE_FIRST, 5, 7'd1);
    send_request(FN_REMOVE_ALL, 5, 7'd1);
    send_request(FN_SEARCH, 5, 7'd1);
    send_request(FN_COUNT_GT, VAL_MIN, 7'd1);
    send_request(FN_UNUSED, -1, 7'd127);
    // A position on an empty list still places the value as the only entry.
    send_request(FN_INSERT_AT, 42, 7'd9);
  endtask

  task automatic test_insert_forms();
    send_request(FN_PUSH_FRONT, VAL_MAX, 7'd0);
    send_request(FN_PUSH_BACK, VAL_MIN, 7'd64);
    send_request(FN_INSERT_AT, -1, 7'd0);
    send_request(FN_INSERT_AT, 0, 7'd127);
    send_request(FN_INSERT_AT, 7, 7'd2);
    send_request(FN_PUSH_BACK, 7, 7'd85);
  endtask

  task automatic test_lookup_and_removal();
    send_request(FN_SEARCH, 7, 7'd0);
    send_request(FN_SEARCH, 12345, 7'd0);
    send_request(FN_COUNT_GT, VAL_MIN, 7'd0);
    send_request(FN_COUNT_GT, VAL_MAX, 7'd0);
    send_request(FN_COUNT_GT, 0, 7'd0);
    send_request(FN_REMOVE_FIRST, 7, 7'd0);
    send_request(FN_REMOVE_FIRST, 999, 7'd0);
    send_request(FN_REMOVE_ALL, 999, 7'd0);
    send_request(FN_PUSH_FRONT, 7, 7'd0);
    send_request(FN_REMOVE_ALL, 7, 7'd0);
    send_request(FN_UNUSED, 7, 7'd42);
  endtask

  task automatic test_capacity_limits();
    while (list_model.size() > 0) send_request(FN_REMOVE_ALL, list_model[0], pick_position());
    while (list_model.size() < LIST_CAPACITY) send_request(FN_PUSH_BACK, VAL_MAX, pick_position());
    send_request(FN_PUSH_FRONT, 1, 7'd0);
    send_request(FN_PUSH_BACK, 1, 7'd0);
    send_request(FN_INSERT_AT, 1, 7'd5);
    send_request(FN_COUNT_GT, VAL_MIN, 7'd0);
    send_request(FN_REMOVE_ALL, VAL_MAX, 7'd0);
    while (list_model.size() < LIST_CAPACITY) send_request(FN_INSERT_AT, VAL_MIN, pick_position());
    send_request(FN_INSERT_AT, 3, 7'd127);
    send_request(FN_SEARCH, VAL_MIN, 7'd0);
    send_request(FN_COUNT_GT, VAL_MIN, 7'd0);
    send_request(FN_REMOVE_FIRST, VAL_MIN, 7'd0);
  endtask

  // Alternates between growing and shrinking phases so the list swings
  // between empty and full.
  task automatic test_random_traffic(input int n_items);
    int         grow_pct;
    int         roll;
    logic [2:0] f;
    grow_pct = 35;
    for (int k = 0; k < n_items; k++) begin
      if (k % 60 == 0) grow_pct = (grow_pct == 75) ? 35 : 75;
      roll = $urandom_range(99);
      if (roll < 2) f = FN_UNUSED;
      else if (roll < grow_pct) f = 3'($urandom_range(2));
      else f = 3'($urandom_range(6, 3));
      send_request(f, pick_value(), pick_position());
    end
  endtask

  // The receiver holds off while requests keep coming, so the block backs up.
  task automatic test_output_backpressure();
    hold_off_req = 1'b1;
    burst_left = 20;
    repeat (12) send_request(3'($urandom_range(6)), pick_value(), pick_position());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_insert_forms();
    test_lookup_and_removal();
    drain_replies();
    test_capacity_limits();
    drain_replies();
    test_random_traffic(200);
    test_output_backpressure();
    drain_replies();
    test_random_traffic(180);
    drain_replies();
    repeat (2 * LIST_CAPACITY + 16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Receiver stall pattern: a long hold-off when requested, else phases of no, light, heavy and near-constant stall.
  initial begin
    int phase_left;
    int stall_pct;
    phase_left = 0;
    stall_pct = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(300, 50);
          case ($urandom_range(3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 60;
            default: stall_pct = 90;
          endcase
        end
        phase_left--;
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d", $time,
                 out_status);
        mismatch_count++;
      end else begin
        oldest_reply = expected_replies.pop_front();
        check_field("status", oldest_reply.status, out_status);
        check_field("entry_count", oldest_reply.entry_count, out_entry_count);
        check_field("entry_sum", oldest_reply.entry_sum, out_entry_sum);
        check_field("tail_value", oldest_reply.tail_value, out_tail_value);
        check_field("match_position", oldest_reply.match_position, out_match_position);
        check_field("greater_count", oldest_reply.greater_count, out_greater_count);
        check_field("removed_count", oldest_reply.removed_count, out_removed_count);
      end
    end
  end

endmodule
